// ===== hdl/hes_pkg.sv =====
// Package for the heat-equation SSP-RK3 stencil block.
// Holds the field widths, reset values, codes and the control bundle.
// Depends on nothing; every other file of the block uses it.
package hes_pkg;

    localparam int MAX_POINTS_DEF   = 128;
    localparam int SAMPLE_WIDTH_DEF = 24;

    localparam int OP_W       = 2;
    localparam int IDX_W      = 7;
    localparam int ST_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int LP_W       = 7;
    localparam int BETA_W     = 16;
    localparam int STEPS_W    = 16;
    localparam int COEF_W     = 16;
    localparam int PHASE_W    = 2;
    localparam int MSEL_W     = 2;

    localparam logic [LP_W-1:0]    LP_RESET    = 7'd80;
    localparam logic [BETA_W-1:0]  BETA_RESET  = 16'd26561;
    localparam logic [STEPS_W-1:0] STEPS_RESET = 16'd400;

    localparam logic [COEF_W-1:0] COEF_ONE_THIRD  = 16'd21845;
    localparam logic [COEF_W-1:0] COEF_TWO_THIRDS = 16'd43691;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [ST_W-1:0] ST_WRITE = 2'd0;
    localparam logic [ST_W-1:0] ST_RUN   = 2'd1;
    localparam logic [ST_W-1:0] ST_READ  = 2'd2;
    localparam logic [ST_W-1:0] ST_BAD   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LAST_POINT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS      = 2'd2;

    localparam logic [PHASE_W-1:0] PH_S1 = 2'd0;
    localparam logic [PHASE_W-1:0] PH_S2 = 2'd1;
    localparam logic [PHASE_W-1:0] PH_S3 = 2'd2;

    localparam logic [MSEL_W-1:0] MS_LAP = 2'd0;
    localparam logic [MSEL_W-1:0] MS_SUM = 2'd1;
    localparam logic [MSEL_W-1:0] MS_U   = 2'd2;

    typedef struct packed {
        logic               busy;
        logic               zero_we;
        logic               src_issue;
        logic               lap_cap;
        logic               mul_en;
        logic [MSEL_W-1:0]  mul_sel;
        logic               acc_cap;
        logic               wb;
        logic [PHASE_W-1:0] phase;
        logic               fin;
    } t_ctrl;

endpackage

// ===== hdl/hes_mul.sv =====
// Shared multiply-and-round unit: x times c/65536, rounded half up.
// The result is registered; uses hes_pkg for the coefficient width.
module hes_mul #(
    parameter int XW = 27
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [XW-1:0]          i_x,
    input  logic [hes_pkg::COEF_W-1:0]    i_c,
    output logic signed [XW-1:0]          o_m
);

    localparam int PW = XW + hes_pkg::COEF_W + 1;

    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] rnd;
    logic signed [XW-1:0] r_m;

    assign prod = PW'(i_x) * PW'($signed({1'b0, i_c}));
    assign rnd  = prod + $signed(PW'(32768));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m <= rnd[XW+hes_pkg::COEF_W-1:hes_pkg::COEF_W];
        end
    end

    assign o_m = r_m;

endmodule

// ===== hdl/hes_seq.sv =====
// Sequencer of the block: runs the end-point clearing, the three stage sweeps
// per time step and the per-point schedule of the shared unit. Uses hes_pkg.
module hes_seq #(
    parameter int AW = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [AW-1:0]                 i_last,
    input  logic [hes_pkg::STEPS_W-1:0]   i_step_count,
    output hes_pkg::t_ctrl                o_ctrl,
    output logic [AW-1:0]                 o_src_addr,
    output logic [AW-1:0]                 o_pt,
    output logic [AW-1:0]                 o_zero_addr
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_ZERO0 = 11'b000_0000_0010,
        S_ZERO1 = 11'b000_0000_0100,
        S_PRE0  = 11'b000_0000_1000,
        S_PRE1  = 11'b000_0001_0000,
        S_FETCH = 11'b000_0010_0000,
        S_LAP   = 11'b000_0100_0000,
        S_MULA  = 11'b000_1000_0000,
        S_MULB  = 11'b001_0000_0000,
        S_MULC  = 11'b010_0000_0000,
        S_WB    = 11'b100_0000_0000
    } t_state;

    t_state                        r_state, n_state;
    logic [AW-1:0]                 r_pt, n_pt;
    logic [hes_pkg::PHASE_W-1:0]   r_phase, n_phase;
    logic [hes_pkg::STEPS_W-1:0]   r_steps, n_steps;
    logic                          fin;

    always_comb begin
        n_state = r_state;
        n_pt    = r_pt;
        n_phase = r_phase;
        n_steps = r_steps;
        fin     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_state = S_ZERO0;
                    n_steps = i_step_count;
                end
            end
            S_ZERO0: begin
                n_state = S_ZERO1;
            end
            S_ZERO1: begin
                if (r_steps == '0 || i_last < AW'(2)) begin
                    n_state = S_IDLE;
                    fin     = 1'b1;
                end else begin
                    n_state = S_PRE0;
                    n_phase = hes_pkg::PH_S1;
                    n_pt    = AW'(1);
                end
            end
            S_PRE0:  n_state = S_PRE1;
            S_PRE1:  n_state = S_FETCH;
            S_FETCH: n_state = S_LAP;
            S_LAP:   n_state = S_MULA;
            S_MULA: begin
                n_state = (r_phase == hes_pkg::PH_S3) ? S_MULB : S_WB;
            end
            S_MULB:  n_state = S_MULC;
            S_MULC:  n_state = S_WB;
            S_WB: begin
                if (r_pt + AW'(1) < i_last) begin
                    n_pt    = r_pt + AW'(1);
                    n_state = S_FETCH;
                end else if (r_phase == hes_pkg::PH_S3) begin
                    n_steps = r_steps - hes_pkg::STEPS_W'(1);
                    n_phase = hes_pkg::PH_S1;
                    if (r_steps == hes_pkg::STEPS_W'(1)) begin
                        n_state = S_IDLE;
                        n_pt    = '0;
                        fin     = 1'b1;
                    end else begin
                        n_state = S_PRE0;
                        n_pt    = AW'(1);
                    end
                end else begin
                    n_phase = r_phase + hes_pkg::PHASE_W'(1);
                    n_pt    = AW'(1);
                    n_state = S_PRE0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pt    <= '0;
            r_phase <= hes_pkg::PH_S1;
            r_steps <= '0;
        end else begin
            r_state <= n_state;
            r_pt    <= n_pt;
            r_phase <= n_phase;
            r_steps <= n_steps;
        end
    end

    always_comb begin
        o_ctrl.busy      = (r_state != S_IDLE);
        o_ctrl.zero_we   = (r_state == S_ZERO0) || (r_state == S_ZERO1);
        o_ctrl.src_issue = (r_state == S_PRE0) || (r_state == S_PRE1) || (r_state == S_FETCH);
        o_ctrl.lap_cap   = (r_state == S_LAP);
        o_ctrl.mul_en    = (r_state == S_MULA) || (r_state == S_MULB) || (r_state == S_MULC);
        o_ctrl.mul_sel   = (r_state == S_MULB) ? hes_pkg::MS_SUM :
                           (r_state == S_MULC) ? hes_pkg::MS_U : hes_pkg::MS_LAP;
        o_ctrl.acc_cap   = (r_state == S_MULC);
        o_ctrl.wb        = (r_state == S_WB);
        o_ctrl.phase     = r_phase;
        o_ctrl.fin       = fin;
    end

    assign o_src_addr  = (r_state == S_PRE0) ? '0 :
                         (r_state == S_PRE1) ? AW'(1) : r_pt + AW'(1);
    assign o_pt        = r_pt;
    assign o_zero_addr = (r_state == S_ZERO0) ? '0 : i_last;

endmodule

// ===== hdl/hes_dp.sv =====
// Datapath: the grid and the two stage stores, the three-point window,
// the shared multiply unit and the write-back with saturation.
// Uses hes_pkg and hes_mul.
module hes_dp #(
    parameter int AW = 7,
    parameter int SW = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hes_pkg::t_ctrl                i_ctrl,
    input  logic [AW-1:0]                 i_src_addr,
    input  logic [AW-1:0]                 i_pt,
    input  logic [AW-1:0]                 i_zero_addr,
    input  logic [hes_pkg::BETA_W-1:0]    i_beta,
    input  logic                          i_host_we,
    input  logic [AW-1:0]                 i_host_addr,
    input  logic signed [SW-1:0]          i_host_data,
    output logic signed [SW-1:0]          o_grid_rd
);

    localparam int DEPTH = 1 << AW;
    localparam int XW    = SW + 3;
    localparam int ACW   = SW + 4;
    localparam logic signed [ACW-1:0] SMAX = {{(ACW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [ACW-1:0] SMIN = {{(ACW-SW+1){1'b1}}, {(SW-1){1'b0}}};
    localparam logic signed [ACW-1:0] RND2 = ACW'(2);

    logic signed [SW-1:0] grid_mem [DEPTH];
    logic signed [SW-1:0] s1_mem   [DEPTH];
    logic signed [SW-1:0] s2_mem   [DEPTH];

    logic signed [SW-1:0] r_grid_rd, r_s1_rd, r_s2_rd;
    logic signed [SW-1:0] r_w0, r_w1, r_w2, r_u;
    logic signed [XW-1:0] r_acc;
    logic                 r_src_pend;

    logic [AW-1:0]        grid_raddr, grid_waddr, stg_waddr;
    logic                 grid_we, s1_we, s2_we;
    logic signed [SW-1:0] grid_wdata, stg_wdata, src_rd, u;
    logic signed [XW-1:0] lap, mul_x, mul_m;
    logic [hes_pkg::COEF_W-1:0] mul_c;
    logic signed [ACW-1:0] s2_sum, wb_raw;
    logic signed [SW-1:0]  wb_sat;

    always_comb begin
        grid_raddr = i_host_addr;
        if (i_ctrl.busy) begin
            grid_raddr = (i_ctrl.phase == hes_pkg::PH_S1) ? i_src_addr : i_pt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_grid_rd <= grid_mem[grid_raddr];
        r_s1_rd   <= s1_mem[i_src_addr];
        r_s2_rd   <= s2_mem[i_src_addr];
        if (grid_we) begin
            grid_mem[grid_waddr] <= grid_wdata;
        end
        if (s1_we) begin
            s1_mem[stg_waddr] <= stg_wdata;
        end
        if (s2_we) begin
            s2_mem[stg_waddr] <= stg_wdata;
        end
    end

    always_comb begin
        case (i_ctrl.phase)
            hes_pkg::PH_S1: src_rd = r_grid_rd;
            hes_pkg::PH_S2: src_rd = r_s1_rd;
            default:        src_rd = r_s2_rd;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_pend <= 1'b0;
        end else begin
            r_src_pend <= i_ctrl.src_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_src_pend) begin
            r_w0 <= r_w1;
            r_w1 <= r_w2;
            r_w2 <= src_rd;
        end
        if (i_ctrl.lap_cap) begin
            r_u <= r_grid_rd;
        end
        if (i_ctrl.acc_cap) begin
            r_acc <= mul_m;
        end
    end

    assign u   = (i_ctrl.phase == hes_pkg::PH_S1) ? r_w1 : r_u;
    assign lap = XW'(r_w2) - (XW'(r_w1) <<< 1) + XW'(r_w0);

    always_comb begin
        case (i_ctrl.mul_sel)
            hes_pkg::MS_SUM: begin
                mul_x = XW'(r_w1) + mul_m;
                mul_c = hes_pkg::COEF_TWO_THIRDS;
            end
            hes_pkg::MS_U: begin
                mul_x = XW'(u);
                mul_c = hes_pkg::COEF_ONE_THIRD;
            end
            default: begin
                mul_x = lap;
                mul_c = i_beta;
            end
        endcase
    end

    hes_mul #(
        .XW (XW)
    ) u_mul (
        .i_clk (i_clk),
        .i_en  (i_ctrl.mul_en),
        .i_x   (mul_x),
        .i_c   (mul_c),
        .o_m   (mul_m)
    );

    assign s2_sum = (ACW'(u) <<< 1) + ACW'(u) + ACW'(r_w1) + ACW'(mul_m) + RND2;

    always_comb begin
        case (i_ctrl.phase)
            hes_pkg::PH_S1: wb_raw = ACW'(u) + ACW'(mul_m);
            hes_pkg::PH_S2: wb_raw = s2_sum >>> 2;
            default:        wb_raw = ACW'(r_acc) + ACW'(mul_m);
        endcase
        if (wb_raw > SMAX) begin
            wb_sat = SMAX[SW-1:0];
        end else if (wb_raw < SMIN) begin
            wb_sat = SMIN[SW-1:0];
        end else begin
            wb_sat = wb_raw[SW-1:0];
        end
    end

    assign grid_we = i_host_we || i_ctrl.zero_we ||
                     (i_ctrl.wb && i_ctrl.phase == hes_pkg::PH_S3);
    assign s1_we   = i_ctrl.zero_we || (i_ctrl.wb && i_ctrl.phase == hes_pkg::PH_S1);
    assign s2_we   = i_ctrl.zero_we || (i_ctrl.wb && i_ctrl.phase == hes_pkg::PH_S2);

    assign stg_waddr  = i_ctrl.zero_we ? i_zero_addr : i_pt;
    assign stg_wdata  = i_ctrl.zero_we ? '0 : wb_sat;
    assign grid_waddr = i_host_we ? i_host_addr : stg_waddr;
    assign grid_wdata = i_host_we ? i_host_data : stg_wdata;

    assign o_grid_rd = r_grid_rd;

endmodule

// ===== hdl/heat_equation_rk3_stencil_top.sv =====
// Top level of the 1-D heat-equation solver with SSP-RK3 time stepping.
// Holds the configuration registers and the command handshake.
// Uses hes_pkg, hes_seq and hes_dp.
//
// A command beat is taken on a rising edge with i_start high and o_busy low.
// Write and read commands finish at once: their result beat, marked by
// o_done, appears in the cycle after the command, so such commands may
// follow one another in every cycle. A read returns the grid point on
// o_sample_out; every other result shows zero there.
// A run command raises o_busy from the next cycle. It first clears the
// end points, then per time step makes three sweeps over the points
// between 0 and the effective last point: two priming reads, then per
// point the states FETCH, LAP, MULA and WB, the third stage adding MULB
// and MULC; the shared multiplier and one read port per store set the pace.
// The result beat appears in the cycle in which o_busy falls again.
// The receiver cannot stall: each result beat lasts exactly one cycle.
// Reset clears the sequencer and loads the default configuration; the grid
// stores hold no defined values until written.
// Configuration writes take effect at once and are meant for idle periods.
module heat_equation_rk3_stencil_top #(
    parameter int MAX_POINTS   = hes_pkg::MAX_POINTS_DEF,
    parameter int SAMPLE_WIDTH = hes_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [hes_pkg::OP_W-1:0]          i_operation,
    input  logic [hes_pkg::IDX_W-1:0]         i_point_index,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_sample_in,
    output logic                              o_done,
    output logic [hes_pkg::ST_W-1:0]          o_status,
    output logic signed [SAMPLE_WIDTH-1:0]    o_sample_out,
    input  logic                              i_cfg_we,
    input  logic [hes_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hes_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int LW = (AW > hes_pkg::IDX_W) ? AW : hes_pkg::IDX_W;

    logic [hes_pkg::LP_W-1:0]    r_last_point;
    logic [hes_pkg::BETA_W-1:0]  r_beta;
    logic [hes_pkg::STEPS_W-1:0] r_step_count;

    logic                        r_done, r_show_rd;
    logic [hes_pkg::ST_W-1:0]    r_status;

    hes_pkg::t_ctrl              ctrl;
    logic [AW-1:0]               src_addr, pt, zero_addr, last_eff, host_addr;
    logic [LW-1:0]               lp_ext, last_lw;
    logic                        accept, idx_ok, host_we, go;
    logic signed [SAMPLE_WIDTH-1:0] grid_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_point <= hes_pkg::LP_RESET;
            r_beta       <= hes_pkg::BETA_RESET;
            r_step_count <= hes_pkg::STEPS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hes_pkg::CFG_LAST_POINT: r_last_point <= i_cfg_data[hes_pkg::LP_W-1:0];
                hes_pkg::CFG_BETA:       r_beta       <= i_cfg_data[hes_pkg::BETA_W-1:0];
                hes_pkg::CFG_STEPS:      r_step_count <= i_cfg_data[hes_pkg::STEPS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign lp_ext   = LW'(r_last_point);
    assign last_lw  = (lp_ext < LW'(MAX_POINTS - 1)) ? lp_ext : LW'(MAX_POINTS - 1);
    assign last_eff = last_lw[AW-1:0];

    assign accept    = i_start && !ctrl.busy;
    assign idx_ok    = (LW'(i_point_index) <= last_lw);
    assign host_addr = AW'(i_point_index);
    assign host_we   = accept && (i_operation == hes_pkg::OP_WRITE) && idx_ok;
    assign go        = accept && (i_operation == hes_pkg::OP_RUN);

    hes_seq #(
        .AW (AW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (go),
        .i_last       (last_eff),
        .i_step_count (r_step_count),
        .o_ctrl       (ctrl),
        .o_src_addr   (src_addr),
        .o_pt         (pt),
        .o_zero_addr  (zero_addr)
    );

    hes_dp #(
        .AW (AW),
        .SW (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_src_addr  (src_addr),
        .i_pt        (pt),
        .i_zero_addr (zero_addr),
        .i_beta      (r_beta),
        .i_host_we   (host_we),
        .i_host_addr (host_addr),
        .i_host_data (i_sample_in),
        .o_grid_rd   (grid_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done    <= 1'b0;
            r_show_rd <= 1'b0;
            r_status  <= hes_pkg::ST_WRITE;
        end else begin
            r_done    <= (accept && i_operation != hes_pkg::OP_RUN) || ctrl.fin;
            r_show_rd <= accept && (i_operation == hes_pkg::OP_READ) && idx_ok;
            if (ctrl.fin) begin
                r_status <= hes_pkg::ST_RUN;
            end else if (accept) begin
                if (i_operation == hes_pkg::OP_WRITE && idx_ok) begin
                    r_status <= hes_pkg::ST_WRITE;
                end else if (i_operation == hes_pkg::OP_READ && idx_ok) begin
                    r_status <= hes_pkg::ST_READ;
                end else begin
                    r_status <= hes_pkg::ST_BAD;
                end
            end
        end
    end

    assign o_busy       = ctrl.busy;
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_sample_out = r_show_rd ? grid_rd : '0;

endmodule
